// ----- rtl/segi_pkg.sv -----
package segi_pkg;

   // fixed widths of the interface fields
   localparam int unsigned CoordW = 16;

endpackage

// ----- rtl/segi_div_cell.sv -----
// one restoring-division step per cell, carrying the item's payload along
module segi_div_cell #(
   parameter int unsigned DW = 34,
   parameter int unsigned QW = 16,
   parameter int unsigned PW = 98
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          valid_in,
   input  logic [DW-1:0] rem_in,
   input  logic [DW-1:0] dm_in,
   input  logic [QW-1:0] q_in,
   input  logic [PW-1:0] pl_in,
   output logic          valid_out,
   output logic [DW-1:0] rem_out,
   output logic [DW-1:0] dm_out,
   output logic [QW-1:0] q_out,
   output logic [PW-1:0] pl_out
);
   logic          valid_ff;
   logic [DW-1:0] rem_ff, dm_ff;
   logic [QW-1:0] q_ff;
   logic [PW-1:0] pl_ff;
   logic [DW:0]   shifted_in;
   logic          take_in;

   assign shifted_in = {rem_in, 1'b0};
   assign take_in    = shifted_in >= {1'b0, dm_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= take_in ? DW'(shifted_in - {1'b0, dm_in}) : DW'(shifted_in);
         dm_ff  <= dm_in;
         q_ff   <= {q_in[QW-2:0], take_in};
         pl_ff  <= pl_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign dm_out    = dm_ff;
   assign q_out     = q_ff;
   assign pl_out    = pl_ff;
endmodule

// ----- rtl/segment_intersection_unit.sv -----
// throughput: one segment pair per cycle unless stalled; the pipeline is a
//   single row of division cells, one quotient bit per cell, all advancing together
// backpressure stalls the whole pipeline while the output register is full
// reset: synchronous, active high; clears all valid flags, payload not reset
module segment_intersection_unit
   import segi_pkg::*;
#(
   parameter int unsigned T_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [CoordW-1:0] req_ax,
   input  logic signed [CoordW-1:0] req_ay,
   input  logic signed [CoordW-1:0] req_bx,
   input  logic signed [CoordW-1:0] req_by,
   input  logic signed [CoordW-1:0] req_cx,
   input  logic signed [CoordW-1:0] req_cy,
   input  logic signed [CoordW-1:0] req_dx,
   input  logic signed [CoordW-1:0] req_dy,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic signed [CoordW-1:0] rsp_px,
   output logic signed [CoordW-1:0] rsp_py
);
   localparam int unsigned VW = CoordW + 1;   // difference width
   localparam int unsigned MW = 2 * VW;       // product width
   localparam int unsigned SW = MW + 1;       // perp-dot width
   localparam int unsigned DW = MW;           // magnitude width
   localparam int unsigned QW = T_FRAC_BITS;
   // payload through the cells: hit, ax, ay, vbx, vby
   localparam int unsigned PW = 1 + 2 * CoordW + 2 * VW;
   localparam int unsigned NC = T_FRAC_BITS;

   // whole pipeline advances when the output register can take data
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage 1: differences
   logic                 s1_valid_ff;
   logic signed [CoordW-1:0] s1_ax_ff, s1_ay_ff;
   logic signed [VW-1:0] s1_vbx_ff, s1_vby_ff, s1_vdx_ff, s1_vdy_ff;
   logic signed [VW-1:0] s1_vcx_ff, s1_vcy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ax_ff  <= req_ax;
         s1_ay_ff  <= req_ay;
         s1_vbx_ff <= VW'(req_bx) - VW'(req_ax);
         s1_vby_ff <= VW'(req_by) - VW'(req_ay);
         s1_vdx_ff <= VW'(req_dx) - VW'(req_cx);
         s1_vdy_ff <= VW'(req_dy) - VW'(req_cy);
         s1_vcx_ff <= VW'(req_cx) - VW'(req_ax);
         s1_vcy_ff <= VW'(req_cy) - VW'(req_ay);
      end
   end

   // stage 2: six 17x17 products, registered
   logic                 s2_valid_ff;
   logic signed [CoordW-1:0] s2_ax_ff, s2_ay_ff;
   logic signed [VW-1:0] s2_vbx_ff, s2_vby_ff;
   logic signed [MW-1:0] s2_p0_ff, s2_p1_ff, s2_p2_ff, s2_p3_ff, s2_p4_ff, s2_p5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ax_ff  <= s1_ax_ff;
         s2_ay_ff  <= s1_ay_ff;
         s2_vbx_ff <= s1_vbx_ff;
         s2_vby_ff <= s1_vby_ff;
         s2_p0_ff  <= MW'(s1_vby_ff) * MW'(s1_vdx_ff);
         s2_p1_ff  <= MW'(s1_vbx_ff) * MW'(s1_vdy_ff);
         s2_p2_ff  <= MW'(s1_vcy_ff) * MW'(s1_vdx_ff);
         s2_p3_ff  <= MW'(s1_vcx_ff) * MW'(s1_vdy_ff);
         s2_p4_ff  <= MW'(s1_vbx_ff) * MW'(s1_vcy_ff);
         s2_p5_ff  <= MW'(s1_vby_ff) * MW'(s1_vcx_ff);
      end
   end

   // stage 3: perp-dot terms
   logic signed [SW-1:0] den_in, numt_in, numu_in;
   assign den_in  = SW'(s2_p0_ff) - SW'(s2_p1_ff);
   assign numt_in = SW'(s2_p2_ff) - SW'(s2_p3_ff);
   assign numu_in = SW'(s2_p4_ff) - SW'(s2_p5_ff);

   logic                 s3_valid_ff;
   logic signed [CoordW-1:0] s3_ax_ff, s3_ay_ff;
   logic signed [VW-1:0] s3_vbx_ff, s3_vby_ff;
   logic signed [SW-1:0] s3_den_ff, s3_numt_ff, s3_numu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ax_ff   <= s2_ax_ff;
         s3_ay_ff   <= s2_ay_ff;
         s3_vbx_ff  <= s2_vbx_ff;
         s3_vby_ff  <= s2_vby_ff;
         s3_den_ff  <= den_in;
         s3_numt_ff <= numt_in;
         s3_numu_ff <= numu_in;
      end
   end

   // hit test, sign-aware compares without division
   logic hit_c;
   always_comb begin
      if (s3_den_ff > 0) begin
         hit_c = s3_numt_ff > 0 && s3_numt_ff < s3_den_ff
              && s3_numu_ff > 0 && s3_numu_ff < s3_den_ff;
      end else if (s3_den_ff < 0) begin
         hit_c = s3_numt_ff < 0 && s3_numt_ff > s3_den_ff
              && s3_numu_ff < 0 && s3_numu_ff > s3_den_ff;
      end else begin
         hit_c = 1'b0;
      end
   end

   // magnitudes; both fit MW bits given |den| <= 2^33
   logic [SW-1:0] dm_full, rm_full;
   assign dm_full = s3_den_ff[SW-1]  ? SW'(-s3_den_ff)  : SW'(s3_den_ff);
   assign rm_full = s3_numt_ff[SW-1] ? SW'(-s3_numt_ff) : SW'(s3_numt_ff);

   // row of division cells
   logic          c_valid [NC+1];
   logic [DW-1:0] c_rem   [NC+1];
   logic [DW-1:0] c_dm    [NC+1];
   logic [QW-1:0] c_q     [NC+1];
   logic [PW-1:0] c_pl    [NC+1];

   assign c_valid[0] = s3_valid_ff;
   assign c_rem[0]   = DW'(rm_full);
   assign c_dm[0]    = DW'(dm_full);
   assign c_q[0]     = '0;
   assign c_pl[0]    = {hit_c, s3_ax_ff, s3_ay_ff, s3_vbx_ff, s3_vby_ff};

   for (genvar i = 0; i < NC; i++) begin : g_cell
      segi_div_cell #(.DW(DW), .QW(QW), .PW(PW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (c_valid[i]),
         .rem_in    (c_rem[i]),
         .dm_in     (c_dm[i]),
         .q_in      (c_q[i]),
         .pl_in     (c_pl[i]),
         .valid_out (c_valid[i+1]),
         .rem_out   (c_rem[i+1]),
         .dm_out    (c_dm[i+1]),
         .q_out     (c_q[i+1]),
         .pl_out    (c_pl[i+1])
      );
   end

   // unpack the far end of the row
   logic                 e_hit;
   logic signed [CoordW-1:0] e_ax, e_ay;
   logic signed [VW-1:0] e_vbx, e_vby;
   assign {e_hit, e_ax, e_ay, e_vbx, e_vby} = c_pl[NC];

   // stage: magnitude times quotient, registered
   localparam int unsigned PRW = VW + QW;
   logic                 m_valid_ff, m_hit_ff, m_nbx_ff, m_nby_ff;
   logic signed [CoordW-1:0] m_ax_ff, m_ay_ff;
   logic [PRW-1:0]       m_px_ff, m_py_ff;
   logic [VW-1:0]        mag_bx, mag_by;

   assign mag_bx = e_vbx[VW-1] ? VW'(-e_vbx) : VW'(e_vbx);
   assign mag_by = e_vby[VW-1] ? VW'(-e_vby) : VW'(e_vby);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= c_valid[NC];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_hit_ff <= e_hit;
         m_nbx_ff <= e_vbx[VW-1];
         m_nby_ff <= e_vby[VW-1];
         m_ax_ff  <= e_ax;
         m_ay_ff  <= e_ay;
         m_px_ff  <= PRW'(mag_bx) * PRW'(c_q[NC]);
         m_py_ff  <= PRW'(mag_by) * PRW'(c_q[NC]);
      end
   end

   // final add and output register
   logic signed [CoordW-1:0] sx, sy, fx, fy;
   assign sx = CoordW'(m_px_ff >> QW);
   assign sy = CoordW'(m_py_ff >> QW);
   assign fx = m_nbx_ff ? m_ax_ff - sx : m_ax_ff + sx;
   assign fy = m_nby_ff ? m_ay_ff - sy : m_ay_ff + sy;

   logic                 rsp_valid_ff, rsp_hit_ff;
   logic signed [CoordW-1:0] rsp_px_ff, rsp_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff <= m_hit_ff;
         rsp_px_ff  <= m_hit_ff ? fx : '0;
         rsp_py_ff  <= m_hit_ff ? fy : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_px    = rsp_px_ff;
   assign rsp_py    = rsp_py_ff;

`ifndef SYNTHESIS
   // a miss never carries a point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_px == '0 && rsp_py == '0)
      else $error("miss with nonzero point");
   // a stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_px) && $stable(rsp_hit))
      else $error("result changed under stall");
   // ready follows output register occupancy
   a_ready: assert property (@(posedge clock)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready mismatch");
   // a parallel pair never hits
   a_parallel: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_den_ff == '0 |-> !hit_c)
      else $error("hit on zero denominator");
`endif
endmodule

// ----- test/tb_segment_intersection_unit.sv -----
`timescale 1ns / 1ps

module tb_segment_intersection_unit
   import segi_pkg::*;
();

   localparam int unsigned TFrac = 16;
   localparam int unsigned Latency = TFrac + 5;

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct packed {
      coord_type ax, ay, bx, by, cx, cy, dx, dy;
   } seg_pair_type;

   typedef struct packed {
      logic      hit;
      coord_type px;
      coord_type py;
   } crossing_type;

   // one row of the directed table; known marks a typed-in expectation
   typedef struct packed {
      seg_pair_type pair;
      logic         known;
      crossing_type res;
   } directed_row_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_ax = '0, req_ay = '0, req_bx = '0, req_by = '0;
   coord_type req_cx = '0, req_cy = '0, req_dx = '0, req_dy = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_hit;
   coord_type rsp_px, rsp_py;

   crossing_type     pending_crossings[$];
   directed_row_type directed_rows[$];
   int unsigned      mismatch_count = 0;
   bit               stimulus_done = 1'b0;

   always #2 clock = ~clock;

   segment_intersection_unit #(.T_FRAC_BITS(TFrac)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ax(req_ax), .req_ay(req_ay), .req_bx(req_bx), .req_by(req_by),
      .req_cx(req_cx), .req_cy(req_cy), .req_dx(req_dx), .req_dy(req_dy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_px(rsp_px), .rsp_py(rsp_py)
   );

   // exact crossing of segment a-b with segment c-d, no division on the hit test
   function automatic crossing_type predict_crossing(seg_pair_type s);
      longint       vbx, vby, vdx, vdy, vcx, vcy, den, numt, numu, dm, rem, mx, my;
      longint       q;
      bit           hit;
      crossing_type res;
      vbx  = longint'(s.bx) - longint'(s.ax);
      vby  = longint'(s.by) - longint'(s.ay);
      vdx  = longint'(s.dx) - longint'(s.cx);
      vdy  = longint'(s.dy) - longint'(s.cy);
      vcx  = longint'(s.cx) - longint'(s.ax);
      vcy  = longint'(s.cy) - longint'(s.ay);
      den  = vby * vdx - vbx * vdy;
      numt = vcy * vdx - vcx * vdy;
      numu = vbx * vcy - vby * vcx;
      if (den > 0) begin
         hit = numt > 0 && numt < den && numu > 0 && numu < den;
      end else if (den < 0) begin
         hit = numt < 0 && numt > den && numu < 0 && numu > den;
      end else begin
         hit = 1'b0;
      end
      res = '0;
      if (hit) begin
         // restoring division for the fraction bits of t
         dm  = den < 0 ? -den : den;
         rem = numt < 0 ? -numt : numt;
         q   = 0;
         for (int i = 0; i < TFrac; i++) begin
            rem = rem <<< 1;
            q   = q <<< 1;
            if (rem >= dm) begin
               rem = rem - dm;
               q   = q | 1;
            end
         end
         // products truncated toward zero, magnitude then sign
         mx = ((vbx < 0 ? -vbx : vbx) * q) >>> TFrac;
         my = ((vby < 0 ? -vby : vby) * q) >>> TFrac;
         res.hit = 1'b1;
         res.px  = coord_type'(vbx < 0 ? longint'(s.ax) - mx : longint'(s.ax) + mx);
         res.py  = coord_type'(vby < 0 ? longint'(s.ay) - my : longint'(s.ay) + my);
      end
      return res;
   endfunction

   function automatic seg_pair_type make_pair(int ax, int ay, int bx, int by,
                                              int cx, int cy, int dx, int dy);
      seg_pair_type s;
      s.ax = coord_type'(ax); s.ay = coord_type'(ay);
      s.bx = coord_type'(bx); s.by = coord_type'(by);
      s.cx = coord_type'(cx); s.cy = coord_type'(cy);
      s.dx = coord_type'(dx); s.dy = coord_type'(dy);
      return s;
   endfunction

   function automatic coord_type rand_coord(int unsigned span);
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return coord_type'(16'h7fff);
      if (pick == 1) return coord_type'(16'h8000);
      if (pick < 5) return coord_type'($urandom());
      return coord_type'(int'($urandom_range(2 * span)) - int'(span));
   endfunction

   // well-formed crossings mostly: an x shape around a random center
   function automatic seg_pair_type rand_pair();
      seg_pair_type s;
      int           mx, my, r;
      int unsigned  span;
      span = $urandom_range(1) ? 200 : 30000;
      if ($urandom_range(3) == 0) begin
         s.ax = rand_coord(span); s.ay = rand_coord(span);
         s.bx = rand_coord(span); s.by = rand_coord(span);
         s.cx = rand_coord(span); s.cy = rand_coord(span);
         s.dx = rand_coord(span); s.dy = rand_coord(span);
      end else begin
         r  = $urandom_range(span / 2) + 1;
         mx = int'($urandom_range(2 * (32767 - r))) - (32767 - r);
         my = int'($urandom_range(2 * (32767 - r))) - (32767 - r);
         s = make_pair(mx - int'($urandom_range(r)), my - int'($urandom_range(r)),
                       mx + int'($urandom_range(r)), my + int'($urandom_range(r)),
                       mx - int'($urandom_range(r)), my + int'($urandom_range(r)),
                       mx + int'($urandom_range(r)), my - int'($urandom_range(r)));
      end
      return s;
   endfunction

   task automatic add_row(seg_pair_type s, logic known, crossing_type res);
      directed_row_type row;
      row.pair  = s;
      row.known = known;
      row.res   = res;
      directed_rows.push_back(row);
   endtask

   // one transfer on the request side, holding valid until accepted
   task automatic send_pair(seg_pair_type s, crossing_type res);
      req_valid <= 1'b1;
      req_ax <= s.ax; req_ay <= s.ay; req_bx <= s.bx; req_by <= s.by;
      req_cx <= s.cx; req_cy <= s.cy; req_dx <= s.dx; req_dy <= s.dy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_crossings.push_back(res);
   endtask

   // stimulus: directed table, then random bursts with gaps
   initial begin
      seg_pair_type s;
      crossing_type exp_res;
      int unsigned  burst;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain x crossing at the origin
      add_row(make_pair(-10, -10, 10, 10, -10, 10, 10, -10), 1'b1, '{1'b1, 16'sd0, 16'sd0});
      // parallel and degenerate pairs give a zero denominator
      add_row(make_pair(0, 0, 10, 0, 0, 5, 10, 5), 1'b1, '0);
      add_row(make_pair(3, 3, 3, 3, -5, 2, 7, 9), 1'b1, '0);
      add_row(make_pair(0, 0, 10, 10, 20, 20, 30, 30), 1'b1, '0);
      add_row('0, 1'b1, '0);
      // crossing exactly on an endpoint is a miss
      add_row(make_pair(0, 0, 10, 0, 0, -5, 0, 5), 1'b1, '0);
      add_row(make_pair(0, 0, 10, 0, 10, -5, 10, 5), 1'b1, '0);
      add_row(make_pair(0, 0, 10, 0, 5, 0, 5, 5), 1'b1, '0);
      // crossing beyond either segment
      add_row(make_pair(0, 0, 10, 0, 20, -5, 20, 5), 1'b1, '0);
      add_row(make_pair(0, 0, 10, 0, 5, 1, 5, 5), 1'b1, '0);
      // full-range diagonals through the origin
      add_row(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768),
              1'b0, '0);
      add_row(make_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768),
              1'b0, '0);
      // t just above one half truncates, so x lands one short of the origin
      add_row(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767), 1'b1,
              '{1'b1, -16'sd1, 16'sd0});
      // negative denominator and both orientations
      add_row(make_pair(10, 10, -10, -10, -10, 10, 10, -10), 1'b0, '0);
      add_row(make_pair(0, 0, 7, 3, 1, 5, 6, -4), 1'b0, '0);
      add_row(make_pair(-1, -1, 1, 1, -1, 1, 1, -1), 1'b1, '{1'b1, 16'sd0, 16'sd0});
      add_row(make_pair(100, -300, -250, 400, -300, -200, 500, 100), 1'b0, '0);
      add_row(make_pair(-32768, -32768, -32766, -32766, -32768, -32766, -32766, -32768),
              1'b0, '0);
      add_row(make_pair(32767, 32767, 32765, 32765, 32767, 32765, 32765, 32767),
              1'b0, '0);

      foreach (directed_rows[i]) begin
         exp_res = directed_rows[i].known ? directed_rows[i].res
                                          : predict_crossing(directed_rows[i].pair);
         send_pair(directed_rows[i].pair, exp_res);
      end

      for (int n = 0; n < 700; ) begin
         burst = $urandom_range(40, 1);
         for (int k = 0; k < burst && n < 700; k++, n++) begin
            s = rand_pair();
            send_pair(s, predict_crossing(s));
         end
         if ($urandom_range(3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // receiver stalls in randomly chosen phases: open stretches or random stall patterns
   initial begin
      int unsigned phase;
      @(negedge reset);
      forever begin
         phase = $urandom_range(2);
         repeat ($urandom_range(60, 10)) begin
            @(posedge clock);
            case (phase)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= 1'($urandom_range(1));
               end
               default: begin
                  rsp_ready <= ($urandom_range(5) == 0);
               end
            endcase
         end
      end
   end

   // compare each result transfer with the oldest expected crossing
   always @(posedge clock) begin
      crossing_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_crossings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transfer hit=%0d px=%0d py=%0d",
                        rsp_hit, rsp_px, rsp_py);
         end else begin
            exp_res = pending_crossings.pop_front();
            if (rsp_hit !== exp_res.hit || rsp_px !== exp_res.px ||
                rsp_py !== exp_res.py) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp hit=%0d px=%0d py=%0d got hit=%0d px=%0d py=%0d",
                           exp_res.hit, exp_res.px, exp_res.py,
                           rsp_hit, rsp_px, rsp_py);
            end
         end
      end
   end

   // end of run once every expected result has drained
   initial begin
      wait (stimulus_done);
      wait (pending_crossings.size() == 0);
      repeat (Latency * 2) @(posedge clock);
      if (mismatch_count == 0 && pending_crossings.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/segi_pkg.sv
rtl/segi_div_cell.sv
rtl/segment_intersection_unit.sv
test/tb_segment_intersection_unit.sv
